### rtl/core/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
`default_nettype none
package stq_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_IDLE    = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  timer_id;
    logic [63:0] expiry_time;
    logic [63:0] reload_interval;
    logic [63:0] current_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [3:0] expired_id;
    logic       last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_LINK,
    ST_SCAN,
    ST_FIRE,
    ST_DONE
  } eng_state_t;

  localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage
`default_nettype wire

### rtl/core/stq_front.sv
// Command intake: a small queue of decoded command words.
`default_nettype none
module stq_front #(
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  stq_pkg::in_word_t push_word,
  output logic              full,
  input  wire               pop,
  output logic              empty,
  output stq_pkg::in_word_t head_word
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  stq_pkg::in_word_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

### rtl/core/stq_engine.sv
// Queue engine: keeps timers in expiry order and runs start, stop and tick.
`default_nettype none
module stq_engine #(
  parameter int NUM_TIMERS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cmd_valid,
  input  stq_pkg::in_word_t  cmd_word,
  output logic               cmd_pop,
  output logic               res_valid,
  output stq_pkg::out_word_t res_word
);
  localparam int IW = $clog2(NUM_TIMERS);
  localparam int LW = IW + 1;

  stq_pkg::eng_state_t state_r, state_nxt;

  logic [IW-1:0]   order_r [NUM_TIMERS];
  logic [63:0]     exp_r   [NUM_TIMERS];
  logic [63:0]     ivl_r   [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] queued_r, fired_r;
  logic [LW-1:0]   len_r;
  stq_pkg::in_word_t cur_r;
  logic            any_r;
  logic [IW-1:0]   tid_r;
  logic            relink_r;

  // The id is valid only when it is below NUM_TIMERS.
  logic          id_ok;
  logic [IW-1:0] cmd_id;
  assign cmd_id = IW'(cur_r.timer_id);
  assign id_ok  = (int'(cur_r.timer_id) < NUM_TIMERS);

  // Position of the first unfired entry, the slot for insertion and the entry to delete.
  logic [LW-1:0] first_pos;
  logic          first_found;
  logic [LW-1:0] ins_pos;
  logic [LW-1:0] del_pos;
  logic          del_found;
  always_comb begin
    first_pos   = len_r;
    first_found = 1'b0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (LW'(i) < len_r && !fired_r[order_r[i]]) begin
        first_pos   = LW'(i);
        first_found = 1'b1;
      end
    end
  end
  always_comb begin
    ins_pos = len_r;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (LW'(i) < len_r && exp_r[order_r[i]] > exp_r[tid_r] && ins_pos == len_r) begin
        ins_pos = LW'(i);
      end
    end
  end
  always_comb begin
    del_pos   = '0;
    del_found = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (LW'(i) < len_r && order_r[i] == tid_r && !del_found) begin
        del_pos   = LW'(i);
        del_found = 1'b1;
      end
    end
  end

  logic [IW-1:0] head_id;
  logic          head_due;
  logic [63:0]   sum;
  logic          carry;
  assign head_id  = order_r[first_pos[IW-1:0]];
  assign head_due = first_found && (exp_r[head_id] <= cur_r.current_time);
  assign {carry, sum} = {1'b0, exp_r[tid_r]} + {1'b0, ivl_r[tid_r]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stq_pkg::ST_IDLE:   if (cmd_valid) state_nxt = (cmd_word.command == stq_pkg::CMD_TICK)
                                           ? stq_pkg::ST_SCAN : stq_pkg::ST_UNLINK;
      stq_pkg::ST_UNLINK: state_nxt = (id_ok && cur_r.command == stq_pkg::CMD_START)
                                      ? stq_pkg::ST_LINK : stq_pkg::ST_DONE;
      stq_pkg::ST_LINK:   state_nxt = relink_r ? stq_pkg::ST_SCAN : stq_pkg::ST_DONE;
      stq_pkg::ST_SCAN:   state_nxt = head_due ? stq_pkg::ST_FIRE : stq_pkg::ST_DONE;
      stq_pkg::ST_FIRE:   state_nxt = (ivl_r[tid_r] != '0) ? stq_pkg::ST_LINK
                                                          : stq_pkg::ST_SCAN;
      stq_pkg::ST_DONE:   state_nxt = stq_pkg::ST_IDLE;
      default:            state_nxt = stq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state_r == stq_pkg::ST_IDLE) && cmd_valid;
  end

  // Results: expiries are reported one scan late so the final one can be marked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= stq_pkg::ST_IDLE;
      len_r    <= '0;
      queued_r <= '0;
      fired_r  <= '0;
      any_r    <= 1'b0;
      relink_r <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_valid <= 1'b0;
      unique case (state_r)
        stq_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            cur_r    <= cmd_word;
            tid_r    <= IW'(cmd_word.timer_id);
            fired_r  <= '0;
            any_r    <= 1'b0;
            relink_r <= 1'b0;
          end
        end
        stq_pkg::ST_UNLINK: begin
          if (id_ok && (cur_r.command == stq_pkg::CMD_START ||
                        cur_r.command == stq_pkg::CMD_STOP) && queued_r[cmd_id] && del_found) begin
            for (int i = 0; i < NUM_TIMERS - 1; i++) begin
              if (LW'(i) >= del_pos) order_r[i] <= order_r[i+1];
            end
            len_r <= len_r - 1'b1;
            queued_r[cmd_id] <= 1'b0;
          end
          if (id_ok && cur_r.command == stq_pkg::CMD_START) begin
            exp_r[cmd_id] <= cur_r.expiry_time;
            ivl_r[cmd_id] <= cur_r.reload_interval;
          end
        end
        stq_pkg::ST_LINK: begin
          if (len_r < LW'(NUM_TIMERS)) begin
            for (int i = 1; i < NUM_TIMERS; i++) begin
              if (LW'(i) > ins_pos) order_r[i] <= order_r[i-1];
            end
            order_r[ins_pos[IW-1:0]] <= tid_r;
            len_r <= len_r + 1'b1;
            queued_r[tid_r] <= 1'b1;
          end
        end
        stq_pkg::ST_SCAN: begin
          if (head_due) begin
            if (any_r) begin
              res_valid <= 1'b1;
              res_word  <= '{stq_pkg::KIND_EXPIRED, 4'(tid_r), 1'b0};
            end
            tid_r <= head_id;
            for (int i = 0; i < NUM_TIMERS - 1; i++) begin
              if (LW'(i) >= first_pos) order_r[i] <= order_r[i+1];
            end
            len_r <= len_r - 1'b1;
            queued_r[head_id] <= 1'b0;
            fired_r[head_id]  <= 1'b1;
            any_r <= 1'b1;
          end
        end
        stq_pkg::ST_FIRE: begin
          if (ivl_r[tid_r] != '0) begin
            exp_r[tid_r] <= carry ? stq_pkg::TIME_MAX : sum;
            relink_r <= 1'b1;
          end
        end
        stq_pkg::ST_DONE: begin
          res_valid <= 1'b1;
          if (cur_r.command == stq_pkg::CMD_TICK) begin
            res_word <= any_r ? '{stq_pkg::KIND_EXPIRED, 4'(tid_r), 1'b1}
                              : '{stq_pkg::KIND_IDLE, 4'd0, 1'b1};
          end else begin
            res_word <= '{stq_pkg::KIND_ACK, 4'd0, 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(NUM_TIMERS)) else $error("queue length overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == int'(len_r)) else $error("flags disagree with length");
  a_done_res: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == stq_pkg::ST_DONE |=> res_valid && res_word.last_of_run)
    else $error("missing final result");
`endif
endmodule
`default_nettype wire

### rtl/core/sorted_timer_queue.sv
// Top level of the sorted timer queue.
// Start: unlink, link (valid id only) and done steps run before the acknowledge word.
// Stop or unused code: unlink, then done. Tick: a scan and a fire per expired timer,
// a link per periodic relink, then a final scan and done; the single shared engine sets the rate.
// Commands queue in a two-entry buffer while the engine works.
// Synchronous active-low reset empties the timer queue; results cannot be stalled.
`default_nettype none
module sorted_timer_queue #(
  parameter int NUM_TIMERS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  stq_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output stq_pkg::out_word_t out_word
);
  logic              full, empty, pop;
  stq_pkg::in_word_t head;

  assign busy = full;

  stq_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n), .push(start && !full), .push_word(in_word),
    .full(full), .pop(pop), .empty(empty), .head_word(head)
  );

  stq_engine #(.NUM_TIMERS(NUM_TIMERS)) u_engine (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!empty), .cmd_word(head),
    .cmd_pop(pop), .res_valid(out_strobe), .res_word(out_word)
  );
endmodule
`default_nettype wire
